// File: hdl/bwr_pkg.sv
package bwr_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 32;

   localparam logic [CsrIndexWidth-1:0] CSR_RAMP_STEP        = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_RAMP_PERIOD_MS   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_MODULATION   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_DETECT_DISTANCE  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_BOOST_GAIN       = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_STALL_LIMIT_MS   = 3'd5;

   localparam logic [1:0] STATUS_RUNNING = 2'd0;
   localparam logic [1:0] STATUS_FOUND   = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

   // more than 0.01 cycle in raw q16.16 units
   localparam logic [33:0] MoveEpsRaw = 34'd655;

   localparam logic [15:0] RampStepReset      = 16'd164;
   localparam logic [15:0] RampPeriodReset    = 16'd100;
   localparam logic [15:0] MaxModulationReset = 16'd16384;
   localparam logic [30:0] DetectReset        = 31'd16384;
   localparam logic [15:0] TorqueMarginReset  = 16'd4096;
   localparam logic [31:0] StallTimeoutReset  = 32'd2000;

   typedef struct packed {
      logic [15:0] ramp_step;
      logic [15:0] ramp_period_ms;
      logic [15:0] max_modulation;
      logic [30:0] detect_distance;
      logic [15:0] boost_gain;
      logic [31:0] stall_limit_ms;
   } cfg_type;

   typedef struct packed {
      logic               started;
      logic signed [31:0] reference_position;
      logic signed [32:0] last_moved_position;
      logic [31:0]        last_ramp_time;
      logic [31:0]        last_move_time;
      logic [15:0]        modulation;
   } state_type;

endpackage

// File: hdl/breakaway_ramp_finder.sv
// breakaway ramp finder: open-loop breakaway search for a motor drive
//
// req channel: one transaction per control-loop update, carrying a free-running
// millisecond time and the signed q16.16 encoder position
// rsp channel: one transaction per request, the modulation depth (q2.14) and a
// status of running, breakaway found or stall timeout
// csr channel: register index and data, always ready; writes are meant to
// happen only while no request is in flight
//
// a request lands in an input register, and one pass of update logic
// (subtract and compare on the position, one 16x16 multiply) writes the search
// state and the result register once the result register is free or being
// taken: rsp_valid rises when the result register is written, and one
// transaction is taken every cycle when rsp_ready stays high
// when the receiver stalls, the result register holds and the input register
// still takes one more request; req_ready drops once both are full
// reset clears the search state and loads the default register values; the
// first request after reset arms the search again
module breakaway_ramp_finder
   import bwr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [31:0]              req_time_ms,
   input  logic signed [31:0]       req_encoder_position,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [15:0]              rsp_drive_modulation,
   output logic [1:0]               rsp_ramp_status,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   cfg_type            cfg_ff;
   state_type          state_ff;
   state_type          state_in;
   logic               in_valid_ff;
   logic [31:0]        in_time_ff;
   logic signed [31:0] in_pos_ff;
   logic               rsp_valid_ff;
   logic [15:0]        rsp_mod_ff;
   logic [1:0]         rsp_status_ff;
   logic [15:0]        mod_in;
   logic [1:0]         status_in;
   logic               fire;

   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign csr_ready = 1'b1;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_drive_modulation = rsp_mod_ff;
   assign rsp_ramp_status      = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_step       <= RampStepReset;
         cfg_ff.ramp_period_ms  <= RampPeriodReset;
         cfg_ff.max_modulation  <= MaxModulationReset;
         cfg_ff.detect_distance <= DetectReset;
         cfg_ff.boost_gain      <= TorqueMarginReset;
         cfg_ff.stall_limit_ms  <= StallTimeoutReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RAMP_STEP:       cfg_ff.ramp_step       <= csr_data[15:0];
            CSR_RAMP_PERIOD_MS:  cfg_ff.ramp_period_ms  <= csr_data[15:0];
            CSR_MAX_MODULATION:  cfg_ff.max_modulation  <= csr_data[15:0];
            CSR_DETECT_DISTANCE: cfg_ff.detect_distance <= csr_data[30:0];
            CSR_BOOST_GAIN:      cfg_ff.boost_gain      <= csr_data[15:0];
            CSR_STALL_LIMIT_MS:  cfg_ff.stall_limit_ms  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   bwr_step u_step (
      .cfg              (cfg_ff),
      .cur              (state_ff),
      .time_ms          (in_time_ff),
      .encoder_position (in_pos_ff),
      .nxt              (state_in),
      .drive_modulation (mod_in),
      .ramp_status      (status_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_time_ff <= req_time_ms;
         in_pos_ff  <= req_encoder_position;
      end
      if (fire) begin
         rsp_mod_ff    <= mod_in;
         rsp_status_ff <= status_in;
      end
   end

   // no result can exist before the search is armed
   a_result_needs_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff.started)
      else $error("result present while search not armed");

   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff && state_ff.started)
      else $error("update pass did not produce a result");

   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(in_time_ff) && $stable(in_pos_ff))
      else $error("pending request lost or changed");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_mod_ff)
         && $stable(rsp_status_ff))
      else $error("stalled result changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_status_ff == STATUS_RUNNING || rsp_status_ff == STATUS_FOUND
         || rsp_status_ff == STATUS_TIMEOUT)
      else $error("undefined status code");

endmodule

// File: hdl/bwr_step.sv
module bwr_step
   import bwr_pkg::*;
(
   input  cfg_type            cfg,
   input  state_type          cur,
   input  logic [31:0]        time_ms,
   input  logic signed [31:0] encoder_position,
   output state_type          nxt,
   output logic [15:0]        drive_modulation,
   output logic [1:0]         ramp_status
);

   logic signed [31:0] ref_pos;
   logic signed [32:0] last_moved;
   logic [31:0]        last_ramp;
   logic [31:0]        last_move;
   logic signed [32:0] moved;
   logic signed [33:0] move_delta;
   logic [33:0]        move_delta_abs;
   logic [32:0]        moved_abs;
   logic               move_mark;
   logic               found;
   logic [31:0]        product;
   logic [19:0]        boosted;
   logic [15:0]        boost_sat;
   logic               ramp_due;
   logic [16:0]        ramp_sum;
   logic [15:0]        ramp_mod;
   logic [31:0]        stall_time;

   // the first transaction captures reference and both time marks
   assign ref_pos    = cur.started ? cur.reference_position : encoder_position;
   assign last_moved = cur.started ? cur.last_moved_position
                                   : 33'(encoder_position);
   assign last_ramp  = cur.started ? cur.last_ramp_time : time_ms;
   assign last_move  = cur.started ? cur.last_move_time : time_ms;

   assign moved          = 33'(encoder_position) - 33'(ref_pos);
   assign move_delta     = 34'(moved) - 34'(last_moved);
   assign move_delta_abs = move_delta[33] ? 34'(-move_delta) : 34'(move_delta);
   assign moved_abs      = moved[32] ? 33'(-moved) : 33'(moved);
   assign move_mark      = move_delta_abs > MoveEpsRaw;
   assign found          = moved_abs >= {2'b00, cfg.detect_distance};

   assign product   = cur.modulation * cfg.boost_gain;
   assign boosted   = product[31:12];
   assign boost_sat = (boosted > {4'h0, cfg.max_modulation}) ? cfg.max_modulation
                                                             : boosted[15:0];

   assign ramp_due = (time_ms - last_ramp) >= {16'h0000, cfg.ramp_period_ms};
   assign ramp_sum = {1'b0, cur.modulation} + {1'b0, cfg.ramp_step};
   assign ramp_mod = (ramp_sum > {1'b0, cfg.max_modulation}) ? cfg.max_modulation
                                                             : ramp_sum[15:0];

   always_comb begin
      nxt.started             = 1'b1;
      nxt.reference_position  = ref_pos;
      nxt.last_moved_position = move_mark ? moved : last_moved;
      nxt.last_move_time      = move_mark ? time_ms : last_move;
      nxt.last_ramp_time      = last_ramp;
      nxt.modulation          = cur.modulation;
      ramp_status             = STATUS_RUNNING;
      stall_time              = time_ms - nxt.last_move_time;
      if (found) begin
         nxt.modulation = boost_sat;
         ramp_status    = STATUS_FOUND;
      end else begin
         if (ramp_due) begin
            nxt.last_ramp_time = time_ms;
            nxt.modulation     = ramp_mod;
         end
         if (nxt.modulation >= cfg.max_modulation && stall_time > cfg.stall_limit_ms) begin
            ramp_status = STATUS_TIMEOUT;
         end
      end
      drive_modulation = nxt.modulation;
   end

endmodule
